@@ rtl/core/fcdma_pkg.sv @@
// Package for the four-channel DMA controller: actions, register selects,
// control bit positions, address step modes, item and result types. No dependencies.
package fcdma_pkg;

  localparam int CHANNEL_COUNT_DEF = 4;
  localparam int COUNT_BITS_DEF    = 21;

  localparam logic [31:0] ADDR_MASK = 32'h0FFF_FFFF;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_REQ   = 2'd2,
    ACT_TICK  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    SEL_SRC  = 2'd0,
    SEL_DST  = 2'd1,
    SEL_CTL  = 2'd2,
    SEL_FILL = 2'd3
  } sel_t;

  // Address step modes
  localparam logic [1:0] MODE_INC    = 2'd0;
  localparam logic [1:0] MODE_DEC    = 2'd1;
  localparam logic [1:0] MODE_FIXED  = 2'd2;
  localparam logic [1:0] MODE_RELOAD = 2'd3;

  localparam int BIT_DMODE  = 21;
  localparam int BIT_SMODE  = 23;
  localparam int BIT_REPEAT = 25;
  localparam int BIT_WORD   = 26;
  localparam int BIT_TIMING = 27;
  localparam int BIT_IRQ    = 30;
  localparam int BIT_ENABLE = 31;

  localparam logic [2:0] TIMING_IMMEDIATE = 3'd0;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  channel;
    logic [1:0]  reg_select;
    logic [31:0] write_data;
    logic [31:0] write_bits;
    logic [2:0]  request_timing;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        copy_valid;
    logic [31:0] copy_source;
    logic [31:0] copy_dest;
    logic        copy_is_word;
    logic [3:0]  irq_raise;
    logic        busy_res;
  } result_t;

  // One address step by mode and unit size, modulo 2^32
  function automatic logic [31:0] step_addr(input logic [31:0] a, input logic [1:0] mode,
                                            input logic word);
    logic [31:0] mag;
    mag = word ? 32'd4 : 32'd2;
    unique case (mode)
      MODE_INC, MODE_RELOAD: step_addr = a + mag;
      MODE_DEC:              step_addr = a - mag;
      default:               step_addr = a;
    endcase
  endfunction

endpackage

@@ rtl/core/fcdma_if.sv @@
// Valid/ready channel interface carrying one payload.
// Depends on nothing; payload type given as a parameter.
interface fcdma_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/fcdma_front.sv @@
// Front end: accepts transactions into a two-entry queue toward the engine.
// Depends on fcdma_pkg.
module fcdma_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fcdma_pkg::item_t     in_data,
  output logic                 q_valid,
  input  logic                 q_ready,
  output fcdma_pkg::item_t     q_data
);
  fcdma_pkg::item_t mem_r [2];
  logic             wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = mem_r[rp_r];

  // pointer and fill update
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("queue overflow");
  a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop && cnt_r != 2'd2 |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("fill count slip");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> cnt_r == $past(cnt_r) - 2'd1) else $error("drain slip");
endmodule

@@ rtl/core/fcdma_engine.sv @@
// Back end: channel registers, pending mask, transfer engine, output register.
// Depends on fcdma_pkg.
module fcdma_engine #(
  parameter int CHANNEL_COUNT = fcdma_pkg::CHANNEL_COUNT_DEF,
  parameter int COUNT_BITS    = fcdma_pkg::COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  fcdma_pkg::item_t     q_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fcdma_pkg::result_t   out_data
);
  localparam int CW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int UW = COUNT_BITS + 1;

  logic [27:0]          src_r  [CHANNEL_COUNT];
  logic [27:0]          dst_r  [CHANNEL_COUNT];
  logic [31:0]          ctl_r  [CHANNEL_COUNT];
  logic [31:0]          fill_r [CHANNEL_COUNT];
  logic [31:0]          ls_r   [CHANNEL_COUNT];
  logic [31:0]          ld_r   [CHANNEL_COUNT];
  logic [UW-1:0]        ul_r   [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] pend_r;

  logic [27:0]          src_nxt  [CHANNEL_COUNT];
  logic [27:0]          dst_nxt  [CHANNEL_COUNT];
  logic [31:0]          ctl_nxt  [CHANNEL_COUNT];
  logic [31:0]          fill_nxt [CHANNEL_COUNT];
  logic [31:0]          ls_nxt   [CHANNEL_COUNT];
  logic [31:0]          ld_nxt   [CHANNEL_COUNT];
  logic [UW-1:0]        ul_nxt   [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] pend_nxt;

  fcdma_pkg::result_t   res_r, res_nxt;
  logic                 ov_r, ov_nxt;
  logic                 take;

  // output register: refills while the taker drains it
  assign q_ready   = !ov_r || out_ready;
  assign take      = q_valid && q_ready;
  assign out_valid = ov_r;
  assign out_data  = res_r;

  function automatic logic [UW-1:0] run_len(input logic [31:0] c);
    logic [COUNT_BITS-1:0] n;
    n = c[COUNT_BITS-1:0];
    run_len = (n == '0) ? {1'b1, {COUNT_BITS{1'b0}}} : {1'b0, n};
  endfunction

  // one transaction of work
  always_comb begin
    logic [CW:0]   pick;
    logic          found;
    logic [31:0]   c, cn;
    logic [31:0]   m;
    logic [UW-1:0] ul;
    logic [CW-1:0] ch;
    logic          ch_ok;
    src_nxt  = src_r;
    dst_nxt  = dst_r;
    ctl_nxt  = ctl_r;
    fill_nxt = fill_r;
    ls_nxt   = ls_r;
    ld_nxt   = ld_r;
    ul_nxt   = ul_r;
    pend_nxt = pend_r;
    res_nxt  = '0;
    pick     = '0;
    found    = 1'b0;
    c        = '0;
    cn       = '0;
    m        = '0;
    ul       = '0;
    ch       = q_data.channel[CW-1:0];
    ch_ok    = ({30'd0, q_data.channel} < CHANNEL_COUNT);
    unique case (fcdma_pkg::action_t'(q_data.action))
      fcdma_pkg::ACT_WRITE: begin
        if (ch_ok) begin
          unique case (fcdma_pkg::sel_t'(q_data.reg_select))
            fcdma_pkg::SEL_SRC: begin
              m = q_data.write_bits & fcdma_pkg::ADDR_MASK;
              src_nxt[ch] = (q_data.write_data[27:0] & m[27:0]) | (src_r[ch] & ~m[27:0]);
            end
            fcdma_pkg::SEL_DST: begin
              m = q_data.write_bits & fcdma_pkg::ADDR_MASK;
              dst_nxt[ch] = (q_data.write_data[27:0] & m[27:0]) | (dst_r[ch] & ~m[27:0]);
            end
            fcdma_pkg::SEL_CTL: begin
              cn = (q_data.write_data & q_data.write_bits) | (ctl_r[ch] & ~q_data.write_bits);
              ctl_nxt[ch] = cn;
              if (!cn[fcdma_pkg::BIT_ENABLE]) begin
                pend_nxt[ch] = 1'b0;
              end else if (!ctl_r[ch][fcdma_pkg::BIT_ENABLE]) begin
                ls_nxt[ch] = {4'd0, src_r[ch]};
                ld_nxt[ch] = {4'd0, dst_r[ch]};
                ul_nxt[ch] = run_len(cn);
                if (cn[fcdma_pkg::BIT_TIMING +: 3] == fcdma_pkg::TIMING_IMMEDIATE)
                  pend_nxt[ch] = 1'b1;
              end
            end
            default: begin
              fill_nxt[ch] = (q_data.write_data & q_data.write_bits) |
                             (fill_r[ch] & ~q_data.write_bits);
            end
          endcase
        end
      end
      fcdma_pkg::ACT_READ: begin
        if (ch_ok) begin
          unique case (fcdma_pkg::sel_t'(q_data.reg_select))
            fcdma_pkg::SEL_SRC: res_nxt.read_data = {4'd0, src_r[ch]};
            fcdma_pkg::SEL_DST: res_nxt.read_data = {4'd0, dst_r[ch]};
            fcdma_pkg::SEL_CTL: res_nxt.read_data = ctl_r[ch];
            default:            res_nxt.read_data = fill_r[ch];
          endcase
        end
      end
      fcdma_pkg::ACT_REQ: begin
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
          if (ctl_r[i][fcdma_pkg::BIT_ENABLE] &&
              ctl_r[i][fcdma_pkg::BIT_TIMING +: 3] == q_data.request_timing)
            pend_nxt[i] = 1'b1;
        end
      end
      default: begin
        // lowest pending channel wins
        for (int i = CHANNEL_COUNT - 1; i >= 0; i--) begin
          if (pend_r[i]) begin
            found = 1'b1;
            pick  = (CW+1)'(i);
          end
        end
        if (found) begin
          c  = ctl_r[pick[CW-1:0]];
          ul = ul_r[pick[CW-1:0]];
          if (ul != '0) begin
            res_nxt.copy_valid   = 1'b1;
            res_nxt.copy_source  = ls_r[pick[CW-1:0]];
            res_nxt.copy_dest    = ld_r[pick[CW-1:0]];
            res_nxt.copy_is_word = c[fcdma_pkg::BIT_WORD];
            ls_nxt[pick[CW-1:0]] = fcdma_pkg::step_addr(ls_r[pick[CW-1:0]],
                c[fcdma_pkg::BIT_SMODE +: 2], c[fcdma_pkg::BIT_WORD]);
            ld_nxt[pick[CW-1:0]] = fcdma_pkg::step_addr(ld_r[pick[CW-1:0]],
                c[fcdma_pkg::BIT_DMODE +: 2], c[fcdma_pkg::BIT_WORD]);
            ul = ul - UW'(1);
          end
          ul_nxt[pick[CW-1:0]] = ul;
          if (ul == '0) begin
            pend_nxt[pick[CW-1:0]] = 1'b0;
            if (c[fcdma_pkg::BIT_REPEAT] &&
                c[fcdma_pkg::BIT_TIMING +: 3] != fcdma_pkg::TIMING_IMMEDIATE) begin
              if (c[fcdma_pkg::BIT_DMODE +: 2] == fcdma_pkg::MODE_RELOAD)
                ld_nxt[pick[CW-1:0]] = {4'd0, dst_r[pick[CW-1:0]]};
              ul_nxt[pick[CW-1:0]] = run_len(c);
            end else begin
              ctl_nxt[pick[CW-1:0]] = {1'b0, c[30:0]};
            end
            // only the first four channels have an interrupt line
            if (c[fcdma_pkg::BIT_IRQ] && (int'(pick) < 4))
              res_nxt.irq_raise = 4'd1 << pick[1:0];
          end
        end
      end
    endcase
    res_nxt.busy_res = (pend_nxt != '0);
    ov_nxt = take ? 1'b1 : (out_ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      ov_r   <= 1'b0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        src_r[i] <= '0; dst_r[i] <= '0; ctl_r[i] <= '0; fill_r[i] <= '0;
        ls_r[i]  <= '0; ld_r[i]  <= '0; ul_r[i]  <= '0;
      end
    end else begin
      ov_r <= ov_nxt;
      if (take) begin
        pend_r <= pend_nxt;
        src_r  <= src_nxt;  dst_r <= dst_nxt; ctl_r <= ctl_nxt; fill_r <= fill_nxt;
        ls_r   <= ls_nxt;   ld_r  <= ld_nxt;  ul_r  <= ul_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) res_r <= res_nxt;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r && $stable(res_r)) else $error("result lost");
  a_irq_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> $onehot0(res_r.irq_raise)) else $error("irq not one-hot");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> res_r.busy_res == (pend_r != '0)) else $error("busy mismatch");
  a_copy_tick: assert property (@(posedge clk) disable iff (!rst_n)
    take && q_data.action != fcdma_pkg::ACT_TICK |=> !res_r.copy_valid)
    else $error("copy outside tick");
endmodule

@@ rtl/core/four_channel_dma_controller_unit.sv @@
// Four-channel DMA controller: top level joining the front queue and engine.
// Depends on fcdma_pkg, fcdma_if, fcdma_front, fcdma_engine.
//
// Usage: the input channel (in_*) takes one transaction per cycle while in_ready is high: a masked
// register write, a register read, a start-timing request or a transfer tick.
// Every transaction gives exactly one result on the output channel (out_*):
// read data, the unit transfer issued by a tick, an interrupt and busy flag.
// A result passes through the queue and then the engine's output register;
// throughput is one transaction per cycle while the receiver keeps up, as the
// engine updates its channel registers from each transaction as it is taken.
// Reset (rst_n low, synchronous) clears all channel registers, live addresses,
// unit counters and pending bits, and empties the queue and output register.
// When the receiver stalls, the result holds, the engine stops and the two-entry
// queue fills; in_ready falls once it is full and rises as results drain.
module four_channel_dma_controller_unit #(
  parameter int CHANNEL_COUNT = fcdma_pkg::CHANNEL_COUNT_DEF,
  parameter int COUNT_BITS    = fcdma_pkg::COUNT_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  fcdma_if.sink   in_ch,
  fcdma_if.source out_ch
);
  logic              q_valid, q_ready;
  fcdma_pkg::item_t  q_data;

  fcdma_front u_front (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready), .in_data (in_ch.data),
    .q_valid, .q_ready, .q_data
  );

  fcdma_engine #(.CHANNEL_COUNT(CHANNEL_COUNT), .COUNT_BITS(COUNT_BITS)) u_engine (
    .clk, .rst_n,
    .q_valid, .q_ready, .q_data,
    .out_valid (out_ch.valid), .out_ready (out_ch.ready), .out_data (out_ch.data)
  );
endmodule

@@ sim/tb_four_channel_dma_controller_unit.sv @@
// Testbench for four_channel_dma_controller_unit: directed table, then random
// register, request and tick traffic, checked against an in-bench channel model.
// Depends on fcdma_pkg, fcdma_if and the RTL of the controller.
`timescale 1ns / 100ps

module tb_four_channel_dma_controller_unit;

  localparam int PHASE_ITEMS = 600;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n;

  fcdma_if #(.payload_t(fcdma_pkg::item_t))   in_if  (clk);
  fcdma_if #(.payload_t(fcdma_pkg::result_t)) out_if (clk);

  four_channel_dma_controller_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #5 clk = ~clk;

  // Channel model state
  logic [27:0] src_reg  [4];
  logic [27:0] dst_reg  [4];
  logic [31:0] ctl_reg  [4];
  logic [31:0] fill_reg [4];
  logic [31:0] live_src [4];
  logic [31:0] live_dst [4];
  logic [21:0] units    [4];
  logic [3:0]  pend;

  fcdma_pkg::result_t expected_results[$];
  int      errors    = 0;
  int      send_idle = 0;
  int      recv_idle = 0;
  logic    in_acc    = 1'b0;
  logic    out_acc   = 1'b0;

  // Directed stimulus table
  typedef struct {
    fcdma_pkg::item_t   it;
    bit                 fixed;
    fcdma_pkg::result_t res;
  } row_t;
  row_t dir_rows[$];

  function automatic logic [21:0] run_len(logic [31:0] c);
    return (c[20:0] == '0) ? 22'h20_0000 : {1'b0, c[20:0]};
  endfunction

  function automatic logic [31:0] advance(logic [31:0] a, logic [1:0] mode, logic word);
    logic [31:0] mag;
    mag = word ? 32'd4 : 32'd2;
    case (mode)
      fcdma_pkg::MODE_DEC:   return a - mag;
      fcdma_pkg::MODE_FIXED: return a;
      default:               return a + mag;
    endcase
  endfunction

  // Applies one transaction to the model and returns the result it gives
  function automatic fcdma_pkg::result_t dma_predict(fcdma_pkg::item_t it);
    fcdma_pkg::result_t r;
    logic [31:0] c;
    logic        old_en;
    int          ch, sel;
    int          hit;
    r   = '0;
    ch  = it.channel;
    sel = it.reg_select;
    case (fcdma_pkg::action_t'(it.action))
      fcdma_pkg::ACT_WRITE: begin
        case (fcdma_pkg::sel_t'(sel))
          fcdma_pkg::SEL_SRC: src_reg[ch] = (it.write_data[27:0] & it.write_bits[27:0]) |
                                            (src_reg[ch] & ~it.write_bits[27:0]);
          fcdma_pkg::SEL_DST: dst_reg[ch] = (it.write_data[27:0] & it.write_bits[27:0]) |
                                            (dst_reg[ch] & ~it.write_bits[27:0]);
          fcdma_pkg::SEL_CTL: begin
            old_en = ctl_reg[ch][fcdma_pkg::BIT_ENABLE];
            c = (it.write_data & it.write_bits) | (ctl_reg[ch] & ~it.write_bits);
            ctl_reg[ch] = c;
            if (!c[fcdma_pkg::BIT_ENABLE]) begin
              pend[ch] = 1'b0;
            end else if (!old_en) begin
              live_src[ch] = {4'b0, src_reg[ch]};
              live_dst[ch] = {4'b0, dst_reg[ch]};
              units[ch]    = run_len(c);
              if (c[fcdma_pkg::BIT_TIMING +: 3] == fcdma_pkg::TIMING_IMMEDIATE)
                pend[ch] = 1'b1;
            end
          end
          default: fill_reg[ch] = (it.write_data & it.write_bits) |
                                  (fill_reg[ch] & ~it.write_bits);
        endcase
      end
      fcdma_pkg::ACT_READ: begin
        case (fcdma_pkg::sel_t'(sel))
          fcdma_pkg::SEL_SRC: r.read_data = {4'b0, src_reg[ch]};
          fcdma_pkg::SEL_DST: r.read_data = {4'b0, dst_reg[ch]};
          fcdma_pkg::SEL_CTL: r.read_data = ctl_reg[ch];
          default:            r.read_data = fill_reg[ch];
        endcase
      end
      fcdma_pkg::ACT_REQ: begin
        for (int i = 0; i < 4; i++)
          if (ctl_reg[i][fcdma_pkg::BIT_ENABLE] &&
              ctl_reg[i][fcdma_pkg::BIT_TIMING +: 3] == it.request_timing)
            pend[i] = 1'b1;
      end
      default: begin
        hit = -1;
        for (int i = 3; i >= 0; i--) if (pend[i]) hit = i;
        if (hit >= 0) begin
          c = ctl_reg[hit];
          if (units[hit] != '0) begin
            r.copy_valid   = 1'b1;
            r.copy_source  = live_src[hit];
            r.copy_dest    = live_dst[hit];
            r.copy_is_word = c[fcdma_pkg::BIT_WORD];
            live_src[hit]  = advance(live_src[hit], c[fcdma_pkg::BIT_SMODE +: 2],
                                     c[fcdma_pkg::BIT_WORD]);
            live_dst[hit]  = advance(live_dst[hit], c[fcdma_pkg::BIT_DMODE +: 2],
                                     c[fcdma_pkg::BIT_WORD]);
            units[hit]     = units[hit] - 1'b1;
          end
          // End of run: reload on repeat with a timed start, else disable
          if (units[hit] == '0) begin
            pend[hit] = 1'b0;
            if (c[fcdma_pkg::BIT_REPEAT] &&
                c[fcdma_pkg::BIT_TIMING +: 3] != fcdma_pkg::TIMING_IMMEDIATE) begin
              if (c[fcdma_pkg::BIT_DMODE +: 2] == fcdma_pkg::MODE_RELOAD)
                live_dst[hit] = {4'b0, dst_reg[hit]};
              units[hit] = run_len(c);
            end else begin
              ctl_reg[hit][fcdma_pkg::BIT_ENABLE] = 1'b0;
            end
            if (c[fcdma_pkg::BIT_IRQ]) r.irq_raise = 4'(1 << hit);
          end
        end
      end
    endcase
    r.busy_res = (pend != '0);
    return r;
  endfunction

  function automatic fcdma_pkg::item_t mk(fcdma_pkg::action_t act, int ch,
                                          fcdma_pkg::sel_t sel, logic [31:0] d,
                                          logic [31:0] m, logic [2:0] tim);
    fcdma_pkg::item_t it;
    it.action         = act;
    it.channel        = 2'(ch);
    it.reg_select     = sel;
    it.write_data     = d;
    it.write_bits     = m;
    it.request_timing = tim;
    return it;
  endfunction

  task automatic add_row(fcdma_pkg::item_t it, bit fixed = 0,
                         fcdma_pkg::result_t res = '0);
    row_t rw;
    rw.it    = it;
    rw.fixed = fixed;
    rw.res   = res;
    dir_rows.push_back(rw);
  endtask

  // Random transaction, mostly well-formed channel set-up with small runs
  function automatic fcdma_pkg::item_t rand_item();
    fcdma_pkg::item_t it;
    logic [95:0]      raw;
    logic [31:0]      d;
    int               pick;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(fcdma_pkg::item_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 40) begin
      it.action = fcdma_pkg::ACT_TICK;
    end else if (pick < 52) begin
      it.action = fcdma_pkg::ACT_REQ;
    end else if (pick < 64) begin
      it.action = fcdma_pkg::ACT_READ;
    end else begin
      it.action = fcdma_pkg::ACT_WRITE;
      if (pick < 82) begin
        it.reg_select = fcdma_pkg::SEL_CTL;
        d = $urandom;
        d[fcdma_pkg::BIT_ENABLE] = ($urandom_range(99) < 70);
        if ($urandom_range(99) < 92) d[20:0] = 21'($urandom_range(8, 1));
        it.write_data = d;
        if ($urandom_range(99) < 80) it.write_bits = '1;
      end else if ($urandom_range(99) < 70) begin
        it.write_bits = '1;
      end
    end
    return it;
  endfunction

  // Sender: hold the transaction until it is taken
  task automatic send_item(fcdma_pkg::item_t it, bit fixed = 0,
                           fcdma_pkg::result_t res = '0);
    fcdma_pkg::result_t pr;
    logic    acc;
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do begin
      @(negedge clk);
      acc = in_if.ready;
      @(posedge clk);
    end while (!acc);
    pr = dma_predict(it);
    expected_results.push_back(fixed ? res : pr);
  endtask

  // Receiver back-pressure
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= rst_n && ($urandom_range(99) >= recv_idle);
    end
  end

  // Result checking at the falling edge, where everything is settled
  always @(negedge clk) begin
    in_acc  <= in_if.valid && in_if.ready;
    out_acc <= out_if.valid && out_if.ready;
    if (rst_n && out_if.valid && out_if.ready) begin
      fcdma_pkg::result_t e, g;
      g = out_if.data;
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction %h", g);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (g.read_data !== e.read_data) begin
          $error("read_data exp %h got %h", e.read_data, g.read_data); errors++;
        end
        if (g.copy_valid !== e.copy_valid) begin
          $error("copy_valid exp %b got %b", e.copy_valid, g.copy_valid); errors++;
        end
        if (g.copy_source !== e.copy_source) begin
          $error("copy_source exp %h got %h", e.copy_source, g.copy_source); errors++;
        end
        if (g.copy_dest !== e.copy_dest) begin
          $error("copy_dest exp %h got %h", e.copy_dest, g.copy_dest); errors++;
        end
        if (g.copy_is_word !== e.copy_is_word) begin
          $error("copy_is_word exp %b got %b", e.copy_is_word, g.copy_is_word); errors++;
        end
        if (g.irq_raise !== e.irq_raise) begin
          $error("irq_raise exp %h got %h", e.irq_raise, g.irq_raise); errors++;
        end
        if (g.busy_res !== e.busy_res) begin
          $error("busy_res exp %b got %b", e.busy_res, g.busy_res); errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  int quiet = 0;
  always @(posedge clk) begin
    if (!rst_n || in_acc || out_acc) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    fcdma_pkg::result_t z;
    z = '0;
    rst_n       <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    for (int i = 0; i < 4; i++) begin
      src_reg[i] = '0; dst_reg[i] = '0; ctl_reg[i] = '0; fill_reg[i] = '0;
      live_src[i] = '0; live_dst[i] = '0; units[i] = '0;
    end
    pend = '0;

    // Reset values, extremes, immediate run with interrupt and address wrap
    add_row(mk(fcdma_pkg::ACT_READ, 0, fcdma_pkg::SEL_SRC, 0, 0, 0), 1, z);
    add_row(mk(fcdma_pkg::ACT_TICK, 0, fcdma_pkg::SEL_SRC, 0, 0, 0), 1, z);
    add_row(mk(fcdma_pkg::ACT_WRITE, 0, fcdma_pkg::SEL_SRC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
    add_row(mk(fcdma_pkg::ACT_READ, 0, fcdma_pkg::SEL_SRC, 0, 0, 0), 1,
            '{read_data: 32'h0FFF_FFFF, default: '0});
    add_row(mk(fcdma_pkg::ACT_WRITE, 0, fcdma_pkg::SEL_DST, 32'h0, 32'hFFFF_FFFF, 0));
    add_row(mk(fcdma_pkg::ACT_WRITE, 3, fcdma_pkg::SEL_FILL, 32'hFFFF_FFFF, 32'h0F0F_0F0F, 0));
    add_row(mk(fcdma_pkg::ACT_READ, 3, fcdma_pkg::SEL_FILL, 0, 0, 0), 1,
            '{read_data: 32'h0F0F_0F0F, default: '0});
    add_row(mk(fcdma_pkg::ACT_WRITE, 0, fcdma_pkg::SEL_CTL, 32'hC420_0002, 32'hFFFF_FFFF, 0));
    add_row(mk(fcdma_pkg::ACT_TICK, 0, fcdma_pkg::SEL_SRC, 0, 0, 0));
    add_row(mk(fcdma_pkg::ACT_TICK, 0, fcdma_pkg::SEL_SRC, 0, 0, 0));
    add_row(mk(fcdma_pkg::ACT_TICK, 0, fcdma_pkg::SEL_SRC, 0, 0, 0));
    // Timed repeat run with destination reload
    add_row(mk(fcdma_pkg::ACT_WRITE, 1, fcdma_pkg::SEL_DST, 32'h0000_1000, 32'hFFFF_FFFF, 0));
    add_row(mk(fcdma_pkg::ACT_WRITE, 1, fcdma_pkg::SEL_CTL, 32'hDA60_0001, 32'hFFFF_FFFF, 0));
    add_row(mk(fcdma_pkg::ACT_REQ, 0, fcdma_pkg::SEL_SRC, 0, 0, 3));
    add_row(mk(fcdma_pkg::ACT_TICK, 0, fcdma_pkg::SEL_SRC, 0, 0, 0));
    add_row(mk(fcdma_pkg::ACT_REQ, 0, fcdma_pkg::SEL_SRC, 0, 0, 3));
    add_row(mk(fcdma_pkg::ACT_TICK, 0, fcdma_pkg::SEL_SRC, 0, 0, 0));
    add_row(mk(fcdma_pkg::ACT_WRITE, 1, fcdma_pkg::SEL_CTL, 32'h0, 32'h8000_0000, 0));
    // Full-length run, then disabled part way through
    add_row(mk(fcdma_pkg::ACT_WRITE, 2, fcdma_pkg::SEL_CTL, 32'h8100_0000, 32'hFFFF_FFFF, 0));
    add_row(mk(fcdma_pkg::ACT_TICK, 0, fcdma_pkg::SEL_SRC, 0, 0, 0));
    add_row(mk(fcdma_pkg::ACT_TICK, 0, fcdma_pkg::SEL_SRC, 0, 0, 0));
    add_row(mk(fcdma_pkg::ACT_WRITE, 2, fcdma_pkg::SEL_CTL, 32'h0, 32'h8000_0000, 0));
    add_row(mk(fcdma_pkg::ACT_REQ, 0, fcdma_pkg::SEL_SRC, 0, 0, 7));
    add_row(mk(fcdma_pkg::ACT_READ, 2, fcdma_pkg::SEL_CTL, 0, 0, 0));
    add_row(mk(fcdma_pkg::ACT_TICK, 0, fcdma_pkg::SEL_SRC, 0, 0, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 38;
    recv_idle = 80;
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].res);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 38 : (phase == 1) ? 80 : 0;
      recv_idle = (phase == 0) ? 80 : (phase == 1) ? 38 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(rand_item());
    end
    in_if.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
